// ===== design/ray_disk_intersection_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray / disk intersection block
// Immediate-consequence and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RAY_DISK_INTERSECTION_ASSERT_SVH
`define RAY_DISK_INTERSECTION_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define RDI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdi assertion failed");

// Consequence holds in the cycle after the antecedent.
`define RDI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdi assertion failed");

`endif

// ===== design/rdi_pkg.sv =====
// ----------------------------------------------------------------------------
// rdi_pkg
// Shared types and constants of the ray / disk intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rdi_pkg;

    // quotient bits below the saturation point, one per divider stage
    localparam int DIV_BITS = 31;

    // register stages in the hit pipe, output register included
    localparam int HIT_STAGES = 6;

    localparam logic [62:0] RADIUS_SQ_RESET = 63'h1_0000_0000;

    localparam logic signed [31:0] DIST_MAX_Q = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DIST_MIN_Q = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] dist_min;
        logic signed [31:0] dist_max;
    } ray_t;

    // item handed from the divider to the hit pipe
    typedef struct packed {
        logic               valid;
        ray_t               ray;
        logic signed [31:0] plane_dist;
        logic               dz_zero;
    } div_out_t;

endpackage

`default_nettype wire

// ===== design/ray_disk_intersection.sv =====
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Depth is set by the plane-distance divider, one quotient bit per stage.
// Reset clears all valid bits and loads radius_sq with 1.0 (Q31.32).
// Payload registers are not reset.
// ----------------------------------------------------------------------------
// ray_disk_intersection
// Ray against an origin-centred disk in the z = 0 plane, Q16.16 fixed point,
// fully pipelined with a single shared advance enable.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_disk_intersection_assert.svh"

module ray_disk_intersection import rdi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // disk radius squared, unsigned Q31.32
    input  wire logic               cfg_wr_en,
    input  wire logic [62:0]        cfg_wr_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] origin_x,
    input  wire logic signed [31:0] origin_y,
    input  wire logic signed [31:0] origin_z,
    input  wire logic signed [31:0] dir_x,
    input  wire logic signed [31:0] dir_y,
    input  wire logic signed [31:0] dir_z,
    input  wire logic signed [31:0] dist_min,
    input  wire logic signed [31:0] dist_max,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit,
    output logic signed [31:0]      distance,
    output logic                    normal_up
);

    logic [62:0] radius_sq_reg;
    logic        adv;
    ray_t        ray_in;
    div_out_t    div_out;

    // Every stage moves together: advance whenever the output register is
    // empty or its item is being taken this cycle. Bubbles travel as
    // cleared valid bits, so a stall simply freezes all stages in place.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        ray_in.origin_x = origin_x;
        ray_in.origin_y = origin_y;
        ray_in.origin_z = origin_z;
        ray_in.dir_x    = dir_x;
        ray_in.dir_y    = dir_y;
        ray_in.dir_z    = dir_z;
        ray_in.dist_min = dist_min;
        ray_in.dist_max = dist_max;
    end

    // radius register; the user must write it only while the pipeline is empty; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_sq_reg <= RADIUS_SQ_RESET;
        else if (cfg_wr_en)
            radius_sq_reg <= cfg_wr_data;
    end

    // Plane distance: sign/magnitude setup, overflow check, then one
    // restoring-division bit per stage and a final sign/saturate stage.
    rdi_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .din_valid (in_valid),
        .din       (ray_in),
        .dout      (div_out)
    );

    // Hit point (t * dir floored to Q16.16), saturating squares, two
    // saturating adds, then compare against the radius and the interval.
    rdi_hit u_hit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .din       (div_out),
        .radius_sq (radius_sq_reg),
        .out_valid (out_valid),
        .hit       (hit),
        .distance  (distance),
        .normal_up (normal_up)
    );

    `RDI_ASSERT_IMP(a_top_normal, clk, rst_n, out_valid, normal_up == hit)

endmodule

`default_nettype wire

// ===== design/rdi_div.sv =====
// ----------------------------------------------------------------------------
// rdi_div
// Pipelined plane-distance divider: t = -origin_z * 2^16 / dir_z, truncated
// toward zero and saturated to 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_disk_intersection_assert.svh"

module rdi_div import rdi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     adv,
    input  wire logic     din_valid,
    input  wire ray_t     din,
    output div_out_t      dout
);

    typedef struct packed {
        ray_t                  ray;
        logic [DIV_BITS-1:0]   nlow;
        logic [31:0]           mag_d;
        logic                  ovf;
        logic                  neg;
        logic                  dz_zero;
    } div_side_t;

    // stage a: magnitudes and sign
    logic          va_reg;
    ray_t          ray_a_reg;
    logic [47:0]   mag_n_a_reg;
    logic [31:0]   mag_d_a_reg;
    logic          neg_a_reg;
    logic          dzz_a_reg;

    logic [31:0]   abs_oz;
    logic [31:0]   abs_dz;
    logic          neg_next;

    // stage b (index 0) and the bit stages (1..DIV_BITS)
    logic [DIV_BITS:0]     dv_reg;
    div_side_t             side_reg [0:DIV_BITS];
    logic [31:0]           rem_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0]   q_reg    [0:DIV_BITS];

    logic [31:0]           rem_next [1:DIV_BITS];
    logic [DIV_BITS-1:0]   q_next   [1:DIV_BITS];
    logic [32:0]           trial    [1:DIV_BITS];
    logic [32:0]           diff     [1:DIV_BITS];

    div_side_t             side_b_next;

    // output stage
    logic                  vo_reg;
    ray_t                  ray_o_reg;
    logic signed [31:0]    dist_o_reg;
    logic                  dzz_o_reg;
    logic signed [31:0]    dist_next;

    always_comb
    begin
        abs_oz   = din.origin_z[31] ? (~din.origin_z + 32'd1) : din.origin_z;
        abs_dz   = din.dir_z[31] ? (~din.dir_z + 32'd1) : din.dir_z;
        // numerator -origin_z is negative when origin_z is positive
        neg_next = (!din.origin_z[31] && (din.origin_z != 32'sd0)) ^ din.dir_z[31];
    end

    always_comb
    begin
        side_b_next.ray     = ray_a_reg;
        side_b_next.nlow    = mag_n_a_reg[DIV_BITS-1:0];
        side_b_next.mag_d   = mag_d_a_reg;
        side_b_next.ovf     = {15'd0, mag_n_a_reg} >= {mag_d_a_reg, 31'd0};
        side_b_next.neg     = neg_a_reg;
        side_b_next.dz_zero = dzz_a_reg;
    end

    // restoring division, one bit per stage
    always_comb
    begin
        for (int k = 1; k <= DIV_BITS; k++)
        begin
            trial[k] = {rem_reg[k-1], side_reg[k-1].nlow[DIV_BITS-k]};
            diff[k]  = trial[k] - {1'b0, side_reg[k-1].mag_d};
            if (trial[k] >= {1'b0, side_reg[k-1].mag_d})
            begin
                rem_next[k] = diff[k][31:0];
                q_next[k]   = {q_reg[k-1][DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][31:0];
                q_next[k]   = {q_reg[k-1][DIV_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (side_reg[DIV_BITS].dz_zero)
            dist_next = 32'sd0;
        else if (side_reg[DIV_BITS].ovf)
            dist_next = side_reg[DIV_BITS].neg ? DIST_MIN_Q : DIST_MAX_Q;
        else if (side_reg[DIV_BITS].neg)
            dist_next = -$signed({1'b0, q_reg[DIV_BITS]});
        else
            dist_next = $signed({1'b0, q_reg[DIV_BITS]});
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            dv_reg <= '0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= din_valid;
            dv_reg <= {dv_reg[DIV_BITS-1:0], va_reg};
            vo_reg <= dv_reg[DIV_BITS];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray_a_reg   <= din;
            mag_n_a_reg <= {abs_oz, 16'd0};
            mag_d_a_reg <= abs_dz;
            neg_a_reg   <= neg_next;
            dzz_a_reg   <= (din.dir_z == 32'sd0);

            side_reg[0] <= side_b_next;
            rem_reg[0]  <= {15'd0, mag_n_a_reg[47:DIV_BITS]};
            q_reg[0]    <= '0;
            for (int k = 1; k <= DIV_BITS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
            end

            ray_o_reg  <= side_reg[DIV_BITS].ray;
            dist_o_reg <= dist_next;
            dzz_o_reg  <= side_reg[DIV_BITS].dz_zero;
        end
    end

    always_comb
    begin
        dout.valid      = vo_reg;
        dout.ray        = ray_o_reg;
        dout.plane_dist = dist_o_reg;
        dout.dz_zero    = dzz_o_reg;
    end

    `RDI_ASSERT_NXT(a_div_freeze, clk, rst_n, !adv, $stable(dv_reg) && $stable(vo_reg))
    `RDI_ASSERT_NXT(a_div_sat, clk, rst_n,
        adv && dv_reg[DIV_BITS] && side_reg[DIV_BITS].ovf && !side_reg[DIV_BITS].dz_zero,
        dist_o_reg == DIST_MAX_Q || dist_o_reg == DIST_MIN_Q)

endmodule

`default_nettype wire

// ===== design/rdi_hit.sv =====
// ----------------------------------------------------------------------------
// rdi_hit
// Hit point, saturating squared radius and interval test, six stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_disk_intersection_assert.svh"

module rdi_hit import rdi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire div_out_t           din,
    input  wire logic [62:0]        radius_sq,
    output logic                    out_valid,
    output logic                    hit,
    output logic signed [31:0]      distance,
    output logic                    normal_up
);

    logic [HIT_STAGES-1:0] vld_reg;

    // stage m: products
    logic                m_range_reg;
    logic                m_range_next;
    logic signed [31:0]  m_t_reg;
    logic signed [31:0]  m_ox_reg, m_oy_reg, m_oz_reg;
    logic signed [63:0]  m_px_reg, m_py_reg, m_pz_reg;
    logic signed [63:0]  m_px_next, m_py_next, m_pz_next;

    // stage p: hit point
    logic                p_range_reg;
    logic signed [31:0]  p_t_reg;
    logic signed [48:0]  p_x_reg, p_y_reg, p_z_reg;
    logic signed [48:0]  p_x_next, p_y_next, p_z_next;

    // stage s: squares
    logic                s_range_reg;
    logic signed [31:0]  s_t_reg;
    logic [63:0]         s_sqx_reg, s_sqy_reg, s_sqz_reg;

    // stage a: first sum
    logic                a_range_reg;
    logic signed [31:0]  a_t_reg;
    logic [63:0]         a_sxy_reg, a_sqz_reg;
    logic [64:0]         a_sum;

    // stage b: second sum
    logic                b_range_reg;
    logic signed [31:0]  b_t_reg;
    logic [63:0]         b_r2_reg;
    logic [64:0]         b_sum;

    // output stage
    logic                hit_reg;
    logic signed [31:0]  dist_reg;

    function automatic logic [63:0] sq_sat(input logic signed [48:0] v);
        logic [48:0] mag;
        mag = v[48] ? (~v + 49'd1) : v;
        if (|mag[48:32])
            return '1;
        return mag[31:0] * mag[31:0];
    endfunction

    always_comb
    begin
        m_range_next = !din.dz_zero && (din.plane_dist > din.ray.dist_min)
                       && (din.plane_dist < din.ray.dist_max);
        m_px_next    = din.plane_dist * din.ray.dir_x;
        m_py_next    = din.plane_dist * din.ray.dir_y;
        m_pz_next    = din.plane_dist * din.ray.dir_z;
    end

    // floor to Q16.16 is an arithmetic shift of the Q32.32 product
    always_comb
    begin
        p_x_next = {{17{m_ox_reg[31]}}, m_ox_reg} + {m_px_reg[63], m_px_reg[63:16]};
        p_y_next = {{17{m_oy_reg[31]}}, m_oy_reg} + {m_py_reg[63], m_py_reg[63:16]};
        p_z_next = {{17{m_oz_reg[31]}}, m_oz_reg} + {m_pz_reg[63], m_pz_reg[63:16]};
    end

    always_comb
    begin
        a_sum = {1'b0, s_sqx_reg} + {1'b0, s_sqy_reg};
        b_sum = {1'b0, a_sxy_reg} + {1'b0, a_sqz_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[HIT_STAGES-2:0], din.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_range_reg <= m_range_next;
            m_t_reg     <= din.plane_dist;
            m_ox_reg    <= din.ray.origin_x;
            m_oy_reg    <= din.ray.origin_y;
            m_oz_reg    <= din.ray.origin_z;
            m_px_reg    <= m_px_next;
            m_py_reg    <= m_py_next;
            m_pz_reg    <= m_pz_next;

            p_range_reg <= m_range_reg;
            p_t_reg     <= m_t_reg;
            p_x_reg     <= p_x_next;
            p_y_reg     <= p_y_next;
            p_z_reg     <= p_z_next;

            s_range_reg <= p_range_reg;
            s_t_reg     <= p_t_reg;
            s_sqx_reg   <= sq_sat(p_x_reg);
            s_sqy_reg   <= sq_sat(p_y_reg);
            s_sqz_reg   <= sq_sat(p_z_reg);

            a_range_reg <= s_range_reg;
            a_t_reg     <= s_t_reg;
            a_sxy_reg   <= a_sum[64] ? '1 : a_sum[63:0];
            a_sqz_reg   <= s_sqz_reg;

            b_range_reg <= a_range_reg;
            b_t_reg     <= a_t_reg;
            b_r2_reg    <= b_sum[64] ? '1 : b_sum[63:0];

            hit_reg     <= b_range_reg && (b_r2_reg <= {1'b0, radius_sq});
            dist_reg    <= b_t_reg;
        end
    end

    assign out_valid = vld_reg[HIT_STAGES-1];
    assign hit       = hit_reg;
    assign normal_up = hit_reg;
    assign distance  = dist_reg;

    `RDI_ASSERT_NXT(a_hit_freeze, clk, rst_n, !adv, $stable(vld_reg))

endmodule

`default_nettype wire

// ===== tb/tb_ray_disk_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_disk_intersection
// Streams rays through the disk intersection pipeline with random stalls on
// both sides, predicts hit, distance and normal for every accepted ray and
// compares each result in order, across several disk radius settings.
// ----------------------------------------------------------------------------

module tb_ray_disk_intersection;
    import rdi_pkg::*;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;   // 1.0 in Q16.16
    localparam logic signed [31:0] QMAX = DIST_MAX_Q;
    localparam logic signed [31:0] QMIN = DIST_MIN_Q;
    localparam logic [62:0] RADIUS_SQ_TOP = {63{1'b1}};
    localparam int RAYS_PER_PHASE = 212;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] distance;
        logic               normal_up;
    } disk_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic [62:0] cfg_wr_data = '0;

    logic in_valid = 1'b0;
    logic in_ready;
    ray_t ray_on_bus = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               hit;
    logic signed [31:0] distance;
    logic               normal_up;

    // rays waiting to be offered, and results owed by the block, oldest first
    ray_t         pending_rays[$];
    disk_result_t expected_results[$];

    // predictor copy of the radius register
    logic [62:0] disk_radius_sq = RADIUS_SQ_RESET;

    int rays_unaccepted = 0;
    int err_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;
    disk_result_t oldest;

    ray_disk_intersection dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .origin_x    (ray_on_bus.origin_x),
        .origin_y    (ray_on_bus.origin_y),
        .origin_z    (ray_on_bus.origin_z),
        .dir_x       (ray_on_bus.dir_x),
        .dir_y       (ray_on_bus.dir_y),
        .dir_z       (ray_on_bus.dir_z),
        .dist_min    (ray_on_bus.dist_min),
        .dist_max    (ray_on_bus.dist_max),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .distance    (distance),
        .normal_up   (normal_up)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // square of a Q16.16 value as Q32.32, pinned at all ones when it overflows
    function automatic logic [63:0] sq_sat(longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        if (m > 64'hFFFF_FFFF)
            return '1;
        return m * m;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic disk_result_t trace_disk(ray_t r);
        disk_result_t res;
        longint       t;
        longint       px;
        longint       py;
        longint       pz;
        logic [63:0]  r2;
        res = '0;
        // parallel ray: nothing to intersect, distance reads as zero
        if (r.dir_z == 0)
            return res;
        // plane distance, truncated toward zero, then clamped to 32 bits
        t = (-longint'(r.origin_z) * 64'sd65536) / longint'(r.dir_z);
        if (t > longint'(QMAX))
            t = longint'(QMAX);
        if (t < longint'(QMIN))
            t = longint'(QMIN);
        res.distance = 32'(t);
        // open interval; an empty one never passes
        if (t > r.dist_min && t < r.dist_max)
        begin
            // products are floored back to Q16.16; the hit point stays wide
            px = longint'(r.origin_x) + ((t * longint'(r.dir_x)) >>> 16);
            py = longint'(r.origin_y) + ((t * longint'(r.dir_y)) >>> 16);
            pz = longint'(r.origin_z) + ((t * longint'(r.dir_z)) >>> 16);
            r2 = add_sat(add_sat(sq_sat(px), sq_sat(py)), sq_sat(pz));
            res.hit = (r2 <= {1'b0, disk_radius_sq});
        end
        res.normal_up = res.hit;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer pending rays, predict at acceptance, insert random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(trace_disk(ray_on_bus));
                rays_unaccepted--;
            end
            // hold the item while it waits; otherwise pick what comes next
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_rays.size() == 0)
                    in_valid <= 1'b0;
                else if (!no_idle && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else
                begin
                    ray_on_bus <= pending_rays.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction,
    // stall the output in random bursts
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no ray outstanding: hit %0b distance %0d",
                           hit, distance);
                    err_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (hit !== oldest.hit)
                    begin
                        $error("hit: expected %0b, got %0b", oldest.hit, hit);
                        err_count++;
                    end
                    if (distance !== oldest.distance)
                    begin
                        $error("distance: expected %0d, got %0d",
                               oldest.distance, distance);
                        err_count++;
                    end
                    if (normal_up !== oldest.normal_up)
                    begin
                        $error("normal_up: expected %0b, got %0b",
                               oldest.normal_up, normal_up);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz,
                             input logic signed [31:0] dmin, dmax);
        ray_t r;
        r.origin_x = ox;
        r.origin_y = oy;
        r.origin_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        r.dist_min = dmin;
        r.dist_max = dmax;
        rays_unaccepted++;
        pending_rays.push_back(r);
    endtask

    // uniform value in [-span, span]
    function automatic longint rand_span(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // block until the pipe holds nothing and every result has been taken
    task automatic wait_drained();
        while (rays_unaccepted != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_radius(input logic [62:0] value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        disk_radius_sq = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n_random);
        longint tq;
        longint dz;
        longint dx;
        longint dy;
        longint ox;
        longint oy;
        longint oz;
        longint dmin;
        longint dmax;
        int     sel;

        // dead-center hit straight down, then the same ray with the distance
        // sitting exactly on either open bound, and an empty interval
        queue_ray(0, 0, ONE, 0, 0, -ONE, 0, 2 * ONE);
        queue_ray(0, 0, ONE, 0, 0, -ONE, ONE, 2 * ONE);
        queue_ray(0, 0, ONE, 0, 0, -ONE, 0, ONE);
        queue_ray(0, 0, ONE, 0, 0, -ONE, 2 * ONE, 0);
        // parallel rays
        queue_ray(0, 0, ONE, ONE, ONE, 0, QMIN, QMAX);
        queue_ray(QMAX, QMIN, QMAX, QMAX, QMIN, 0, QMIN, QMAX);
        // on the rim of a unit disk, and one step past it
        queue_ray(ONE, 0, ONE, 0, 0, -ONE, 0, 2 * ONE);
        queue_ray(ONE + 1, 0, ONE, 0, 0, -ONE, 0, 2 * ONE);
        queue_ray(39322, -39322, ONE, 0, 0, -ONE, 0, 2 * ONE);
        // every field at its top, then at its bottom
        queue_ray(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
        queue_ray(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
        // distance clamped high and low
        queue_ray(0, 0, QMIN, 0, 0, 1, QMIN, QMAX);
        queue_ray(0, 0, QMAX, 0, 0, 1, QMIN, QMAX);
        queue_ray(0, 0, QMIN, 0, 0, -1, QMIN, QMAX);
        // hit point far past 32 bits: its square pins at all ones
        queue_ray(0, 0, -ONE, QMAX, 0, 4, 0, QMAX);
        queue_ray(0, 0, -ONE, 0, QMIN, 4, 0, QMAX);
        // fractional distance with a negative product that floors down
        queue_ray(0, 0, ONE, -1, 3, -3 * ONE, 0, ONE);
        // from below, from behind, and starting on the disk
        queue_ray(0, 0, -2 * ONE, ONE / 4, 0, ONE, 0, QMAX);
        queue_ray(0, 0, ONE, 0, 0, ONE, QMIN, 0);
        queue_ray(0, 0, ONE, 0, 0, ONE, 0, QMAX);
        queue_ray(0, 0, 0, 0, 0, -1, -1, 1);

        for (int i = 0; i < n_random; i++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 2)
                queue_ray($urandom, $urandom, $urandom, $urandom, $urandom, 0,
                          $urandom, $urandom);
            else if (sel < 5)
                queue_ray($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
            else
            begin
                // aim at a point near the disk: back off from it along the
                // direction so that the plane crossing lands close to it
                tq = longint'($urandom_range(0, 64 * ONE));
                if ($urandom_range(0, 7) == 0)
                    tq = -tq;
                dz = ($urandom_range(0, 9) == 0) ? rand_span(16) : rand_span(4 * ONE);
                if (dz == 0)
                    dz = 1;
                dx = rand_span(4 * ONE);
                dy = rand_span(4 * ONE);
                oz = -((tq * dz) >>> 16);
                ox = rand_span(2 * ONE) - ((tq * dx) >>> 16);
                oy = rand_span(2 * ONE) - ((tq * dy) >>> 16);
                dmin = tq - longint'($urandom_range(0, ONE));
                dmax = tq + longint'($urandom_range(0, ONE));
                case ($urandom_range(0, 9))
                    0: dmin = tq;
                    1: dmax = tq;
                    2: dmin = dmax + 1;
                    3: dmin = longint'(QMIN);
                    default: ;
                endcase
                queue_ray(32'(ox), 32'(oy), 32'(oz), 32'(dx), 32'(dy), 32'(dz),
                          32'(dmin), 32'(dmax));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, then one phase per radius setting
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radius as it comes out of reset
        run_phase(RAYS_PER_PHASE);
        // zero radius: only a crossing exactly at the center hits
        write_radius('0);
        run_phase(RAYS_PER_PHASE);
        // widest radius
        write_radius(RADIUS_SQ_TOP);
        run_phase(RAYS_PER_PHASE);
        // a few units across
        write_radius(63'(longint'($urandom_range(1, 16)) << 32));
        run_phase(RAYS_PER_PHASE);
        write_radius(63'({$urandom, $urandom}));
        run_phase(RAYS_PER_PHASE);
        // back to 1.0, with the line kept busy on both sides
        write_radius(RADIUS_SQ_RESET);
        wait_drained();
        no_idle = 1'b1;
        run_phase(RAYS_PER_PHASE);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("ray_disk_intersection: match");
        else
            $display("ray_disk_intersection: mismatch");
        $finish;
    end

    // watchdog: stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ray_disk_intersection: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/rdi_pkg.sv
design/rdi_div.sv
design/rdi_hit.sv
design/ray_disk_intersection.sv
tb/tb_ray_disk_intersection.sv
